FILE: hw/rtl/mec_pkg.sv
// package: types, constants and codes shared by the escape-time classifier
package mec_pkg;

  localparam int DEF_DATA_WIDTH = 32;
  localparam int DEF_FRAC_BITS  = 24;

  // width of one operand slice fed to the multiplier per pass
  localparam int MUL_CHUNK_W = 32;

  localparam int ITER_W  = 8;
  localparam int LIMIT_W = 31;
  localparam int CFG_IDX_W = 3;

  localparam logic [ITER_W-1:0]  RST_MAX_ITERS      = 8'd200;
  localparam logic [LIMIT_W-1:0] RST_ESCAPE_LIMIT   = 31'd67108864;
  localparam logic [LIMIT_W-1:0] RST_BAND_ONE_LIMIT = 31'd73819750;
  localparam logic [LIMIT_W-1:0] RST_BAND_TWO_LIMIT = 31'd100663296;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_ITERS,
    REG_ESCAPE_LIMIT,
    REG_BAND_ONE_LIMIT,
    REG_BAND_TWO_LIMIT
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BAND_BOUNDED,
    BAND_ONE,
    BAND_TWO,
    BAND_BEYOND
  } band_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_XY,
    S_WSQ
  } ctl_state_t;

  typedef struct packed {
    logic signed [31:0] c_real;
    logic signed [31:0] c_imag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         band;
    logic [ITER_W-1:0]  iterations;
    logic [LIMIT_W-1:0] final_magnitude;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic start_xy;
    logic start_sq;
    logic upd_mag;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic cont;
    logic mul_done;
  } dp_sts_t;

endpackage

FILE: hw/rtl/mec_fxmul.sv
// multi-pass signed fixed-point multiplier, floor(a*b / 2^frac) wrapped
module mec_fxmul #(
  parameter int DATA_WIDTH = mec_pkg::DEF_DATA_WIDTH,
  parameter int FRAC_BITS  = mec_pkg::DEF_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [DATA_WIDTH-1:0] b,
  output logic                         done,
  output logic        [DATA_WIDTH-1:0] res
);

  localparam int CHUNK_W = mec_pkg::MUL_CHUNK_W;
  localparam int NC      = (DATA_WIDTH + CHUNK_W - 1) / CHUNK_W;
  localparam int EXT_W   = NC * CHUNK_W;
  localparam int ACC_W   = 2 * EXT_W;
  localparam int CW      = (NC > 1) ? $clog2(NC) : 1;
  localparam int SH_W    = $clog2(ACC_W) + 1;
  localparam int PP_W    = 2 * CHUNK_W + 2;

  logic [NC-1:0][CHUNK_W-1:0] a_r, b_r;
  logic [ACC_W-1:0]           acc_r;
  logic [CW-1:0]              ia_r, ib_r;
  logic                       run_r, done_r;

  logic [CHUNK_W-1:0]        a_ch, b_ch;
  logic signed [CHUNK_W:0]   a_x, b_x;
  logic signed [PP_W-1:0]    pp;
  logic [SH_W-1:0]           shift;
  logic                      last_a, last_b;

  always_comb begin
    a_ch   = a_r[ia_r];
    b_ch   = b_r[ib_r];
    last_a = (ia_r == CW'(NC - 1));
    last_b = (ib_r == CW'(NC - 1));
    a_x    = signed'({last_a & a_ch[CHUNK_W-1], a_ch});
    b_x    = signed'({last_b & b_ch[CHUNK_W-1], b_ch});
    pp     = PP_W'(a_x * b_x);
    shift  = SH_W'((SH_W'(ia_r) + SH_W'(ib_r)) * CHUNK_W);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      ia_r   <= '0;
      ib_r   <= '0;
    end else if (start) begin
      a_r    <= EXT_W'(a);
      b_r    <= EXT_W'(b);
      acc_r  <= '0;
      ia_r   <= '0;
      ib_r   <= '0;
      run_r  <= 1'b1;
      done_r <= 1'b0;
    end else if (run_r) begin
      acc_r  <= acc_r + (ACC_W'(pp) << shift);
      done_r <= last_a && last_b;
      if (last_a && last_b) begin
        run_r <= 1'b0;
      end
      if (last_b) begin
        ib_r <= '0;
        ia_r <= ia_r + CW'(1);
      end else begin
        ib_r <= ib_r + CW'(1);
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign done = done_r;
  assign res  = acc_r[FRAC_BITS+DATA_WIDTH-1:FRAC_BITS];

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !run_r)
    else $error("multiplier restarted while running");
`endif

endmodule

FILE: hw/rtl/mec_datapath.sv
// datapath: configuration registers, z state, multipliers and result register
module mec_datapath #(
  parameter int DATA_WIDTH = mec_pkg::DEF_DATA_WIDTH,
  parameter int FRAC_BITS  = mec_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mec_pkg::in_item_t                   in_data,
  input  logic                                cfg_we,
  input  logic [mec_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mec_pkg::LIMIT_W-1:0]         cfg_wdata,
  input  mec_pkg::dp_cmd_t                    cmd,
  output mec_pkg::dp_sts_t                    sts,
  output logic                                out_valid,
  output mec_pkg::out_item_t                  out_data
);

  localparam int DW = DATA_WIDTH;

  logic [mec_pkg::ITER_W-1:0]  max_iters_r;
  logic [mec_pkg::LIMIT_W-1:0] escape_r, band_one_r, band_two_r;

  logic [DW-1:0] cr_r, ci_r, zr_r, zi_r, rs_r, is_r, mag_r;
  logic [mec_pkg::ITER_W-1:0] n_r;

  logic                out_valid_r;
  mec_pkg::out_item_t  out_data_r, out_nxt;

  logic signed [63:0] cr64, ci64;
  logic [DW-1:0]      zr_nxt, zi_nxt, res0, res1;
  logic               done0, done1;
  logic [DW-1:0]      m0_a, m0_b;
  logic [63:0]        m64;
  logic               mag_neg;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iters_r <= mec_pkg::RST_MAX_ITERS;
      escape_r    <= mec_pkg::RST_ESCAPE_LIMIT;
      band_one_r  <= mec_pkg::RST_BAND_ONE_LIMIT;
      band_two_r  <= mec_pkg::RST_BAND_TWO_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        mec_pkg::REG_MAX_ITERS:      max_iters_r <= cfg_wdata[mec_pkg::ITER_W-1:0];
        mec_pkg::REG_ESCAPE_LIMIT:   escape_r    <= cfg_wdata;
        mec_pkg::REG_BAND_ONE_LIMIT: band_one_r  <= cfg_wdata;
        mec_pkg::REG_BAND_TWO_LIMIT: band_two_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    cr64   = 64'(in_data.c_real);
    ci64   = 64'(in_data.c_imag);
    zr_nxt = rs_r - is_r + cr_r;
    zi_nxt = {res0[DW-2:0], 1'b0} + ci_r;
    m0_a   = cmd.start_xy ? zr_r : zr_r;
    m0_b   = cmd.start_xy ? zi_r : zr_r;
    mag_neg = mag_r[DW-1];
    m64    = 64'(mag_r);
    sts.cont     = (mag_neg || (m64 <= 64'(escape_r))) && (n_r < max_iters_r);
    sts.mul_done = done0 | done1;
  end

  mec_fxmul #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_mul0 (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.start_xy | cmd.start_sq),
    .a    (signed'(m0_a)),
    .b    (signed'(m0_b)),
    .done (done0),
    .res  (res0)
  );

  mec_fxmul #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_mul1 (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.start_sq),
    .a    (signed'(zi_nxt)),
    .b    (signed'(zi_nxt)),
    .done (done1),
    .res  (res1)
  );

  // iteration state
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cr_r  <= cr64[DW-1:0];
      ci_r  <= ci64[DW-1:0];
      zr_r  <= '0;
      zi_r  <= '0;
      rs_r  <= '0;
      is_r  <= '0;
      mag_r <= '0;
      n_r   <= '0;
    end else begin
      if (cmd.start_xy) begin
        zr_r <= zr_nxt;
      end
      if (cmd.start_sq) begin
        zi_r <= zi_nxt;
      end
      if (cmd.upd_mag) begin
        rs_r  <= res0;
        is_r  <= res1;
        mag_r <= res0 + res1;
        n_r   <= n_r + mec_pkg::ITER_W'(1);
      end
    end
  end

  // classification of the final magnitude
  always_comb begin
    out_nxt.iterations = n_r;
    if (mag_neg || (m64 <= 64'(escape_r))) begin
      out_nxt.band = mec_pkg::BAND_BOUNDED;
    end else if (m64 <= 64'(band_one_r)) begin
      out_nxt.band = mec_pkg::BAND_ONE;
    end else if (m64 <= 64'(band_two_r)) begin
      out_nxt.band = mec_pkg::BAND_TWO;
    end else begin
      out_nxt.band = mec_pkg::BAND_BEYOND;
    end
    if (mag_neg) begin
      out_nxt.final_magnitude = '0;
    end else if (m64 > 64'(31'h7FFF_FFFF)) begin
      out_nxt.final_magnitude = '1;
    end else begin
      out_nxt.final_magnitude = m64[mec_pkg::LIMIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_escaped_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.band != mec_pkg::BAND_BOUNDED))
      |-> (out_data_r.final_magnitude != '0))
    else $error("escaped point reported with zero magnitude");
`endif

endmodule

FILE: hw/rtl/mec_ctrl.sv
// controller: sequences load, cross product, squares and the escape check
module mec_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  mec_pkg::dp_sts_t  sts,
  output mec_pkg::dp_cmd_t  cmd
);

  mec_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mec_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      mec_pkg::S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = mec_pkg::S_CHECK;
        end
      end
      mec_pkg::S_CHECK: begin
        if (sts.cont) begin
          cmd.start_xy = 1'b1;
          state_nxt    = mec_pkg::S_XY;
        end else begin
          cmd.emit  = 1'b1;
          state_nxt = mec_pkg::S_IDLE;
        end
      end
      mec_pkg::S_XY: begin
        if (sts.mul_done) begin
          cmd.start_sq = 1'b1;
          state_nxt    = mec_pkg::S_WSQ;
        end
      end
      mec_pkg::S_WSQ: begin
        if (sts.mul_done) begin
          cmd.upd_mag = 1'b1;
          state_nxt   = mec_pkg::S_CHECK;
        end
      end
      default: begin
        state_nxt = mec_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != mec_pkg::S_IDLE);

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && (state_r == mec_pkg::S_CHECK)))
    else $error("accepted point did not start the check");

  a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    sts.mul_done |-> ((state_r == mec_pkg::S_XY) || (state_r == mec_pkg::S_WSQ)))
    else $error("multiplier finished outside a wait phase");

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (state_r == mec_pkg::S_IDLE))
    else $error("result sent without returning to idle");
`endif

endmodule

FILE: hw/rtl/mandelbrot_escape_classifier_top.sv
// top level of the fixed-point escape-time classifier
//
// usage: drive in_data with a point c (signed, FRAC_BITS fraction bits) and
// raise start; the transfer happens at a rising edge where start is high and
// busy is low. busy stays high while the point is iterated.
// the result appears on out_data for exactly one cycle with out_valid high;
// the receiver must take it then, it cannot stall the block. a new start is
// taken in the same cycle as the result strobe.
// each iteration runs the escape check, then the cross product on one
// multiplier, then both squares on that multiplier and a second one; each
// multiply runs P = ceil(DATA_WIDTH/32)^2 serial slice passes.
// configuration: cfg_we, cfg_index and cfg_wdata write one register per edge.
// the user must write only while the block is idle; the block itself does
// not enforce this. indexes beyond the list are ignored.
// reset (rst_n low, synchronous) returns the controller to idle, drops the
// result strobe and loads the register defaults: 200 iterations, escape
// limit 4.0, band limits 4.4 and 6.0.
module mandelbrot_escape_classifier_top #(
  parameter int DATA_WIDTH = mec_pkg::DEF_DATA_WIDTH,
  parameter int FRAC_BITS  = mec_pkg::DEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  mec_pkg::in_item_t              in_data,
  output logic                           out_valid,
  output mec_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [mec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mec_pkg::LIMIT_W-1:0]    cfg_wdata
);

  mec_pkg::dp_cmd_t cmd;
  mec_pkg::dp_sts_t sts;

  mec_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .sts  (sts),
    .cmd  (cmd)
  );

  mec_datapath #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

FILE: verif/mec_escape_checker.sv
// checker for the escape-time classifier: predicts each point's class and compares results
`timescale 1ns / 100ps

module mec_escape_checker
  import mec_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [LIMIT_W-1:0]    cfg_wdata,
  output int                    mismatch_count,
  output int                    outstanding
);

  logic [ITER_W-1:0]  iter_cap;
  logic [LIMIT_W-1:0] escape_bound;
  logic [LIMIT_W-1:0] band_one_bound;
  logic [LIMIT_W-1:0] band_two_bound;

  out_item_t class_q[$];

  // floor of a*b / 2^frac, wrapped to 32 bits
  function automatic logic signed [31:0] fx_mul(logic signed [31:0] a, logic signed [31:0] b);
    longint pa;
    longint pb;
    longint prod;
    pa   = a;
    pb   = b;
    prod = pa * pb;
    return prod[DEF_FRAC_BITS+31:DEF_FRAC_BITS];
  endfunction

  // negative (wrapped) magnitudes sit below every bound
  function automatic bit mag_within(logic signed [31:0] mag, logic [LIMIT_W-1:0] bound);
    return mag[31] || (mag[30:0] <= bound);
  endfunction

  function automatic out_item_t classify_point(in_item_t pt);
    logic signed [31:0] zr;
    logic signed [31:0] zi;
    logic signed [31:0] re_sq;
    logic signed [31:0] im_sq;
    logic signed [31:0] mag;
    logic signed [31:0] zr_zi;
    int                 n;
    out_item_t          res;
    zr    = '0;
    zi    = '0;
    re_sq = '0;
    im_sq = '0;
    mag   = '0;
    n     = 0;
    while (mag_within(mag, escape_bound) && n < int'(iter_cap)) begin
      zr_zi = fx_mul(zr, zi);
      zi    = zr_zi + zr_zi + pt.c_imag;
      zr    = re_sq - im_sq + pt.c_real;
      re_sq = fx_mul(zr, zr);
      im_sq = fx_mul(zi, zi);
      mag   = re_sq + im_sq;
      n++;
    end
    if (mag_within(mag, escape_bound)) begin
      res.band = BAND_BOUNDED;
    end else if (mag_within(mag, band_one_bound)) begin
      res.band = BAND_ONE;
    end else if (mag_within(mag, band_two_bound)) begin
      res.band = BAND_TWO;
    end else begin
      res.band = BAND_BEYOND;
    end
    res.iterations      = n[ITER_W-1:0];
    res.final_magnitude = mag[31] ? '0 : mag[30:0];
    return res;
  endfunction

  always @(posedge clk) begin : track
    out_item_t want;
    int        errs;
    errs = 0;
    if (!rst_n) begin
      iter_cap       <= RST_MAX_ITERS;
      escape_bound   <= RST_ESCAPE_LIMIT;
      band_one_bound <= RST_BAND_ONE_LIMIT;
      band_two_bound <= RST_BAND_TWO_LIMIT;
      class_q.delete();
    end else begin
      if (out_valid) begin
        if (class_q.size() == 0) begin
          $display("%0t: result with no transfer pending, expected none, actual %h",
                   $time, out_data);
          errs++;
        end else begin
          want = class_q.pop_front();
          if (out_data.band !== want.band) begin
            $display("%0t: band expected %0d actual %0d", $time, want.band, out_data.band);
            errs++;
          end
          if (out_data.iterations !== want.iterations) begin
            $display("%0t: iterations expected %0d actual %0d",
                     $time, want.iterations, out_data.iterations);
            errs++;
          end
          if (out_data.final_magnitude !== want.final_magnitude) begin
            $display("%0t: final_magnitude expected %h actual %h",
                     $time, want.final_magnitude, out_data.final_magnitude);
            errs++;
          end
        end
      end
      if (start && !busy) begin
        class_q.push_back(classify_point(in_data));
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_ITERS:      iter_cap       <= cfg_wdata[ITER_W-1:0];
          REG_ESCAPE_LIMIT:   escape_bound   <= cfg_wdata;
          REG_BAND_ONE_LIMIT: band_one_bound <= cfg_wdata;
          REG_BAND_TWO_LIMIT: band_two_bound <= cfg_wdata;
          default: ;
        endcase
      end
    end
    mismatch_count <= mismatch_count + errs;
    outstanding    <= class_q.size();
  end

endmodule

FILE: verif/tb_mandelbrot_escape_classifier_top.sv
// testbench top for the escape-time classifier: stimulus, configuration phases and verdict
`timescale 1ns / 100ps

module tb_mandelbrot_escape_classifier_top;
  import mec_pkg::*;

  localparam int Q_ONE       = 1 << DEF_FRAC_BITS;
  localparam int STALL_LIMIT = 6000;
  localparam int NUM_PHASES  = 12;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  logic                 busy;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LIMIT_W-1:0]   cfg_wdata = '0;

  int mismatch_count;
  int outstanding;
  int stall_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  mandelbrot_escape_classifier_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  mec_escape_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("mandelbrot_escape_classifier_top: mismatch");
    $finish;
  end

  function automatic in_item_t make_point(int re, int im);
    in_item_t pt;
    pt.c_real = re;
    pt.c_imag = im;
    return pt;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  function automatic in_item_t rand_point();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return make_point(int'($urandom_range(0, 58720256)) - 41943040,
                        int'($urandom_range(0, 50331648)) - 25165824);
    end else if (r < 80) begin
      return make_point(int'($urandom_range(0, 6 * Q_ONE)) - 3 * Q_ONE,
                        int'($urandom_range(0, 6 * Q_ONE)) - 3 * Q_ONE);
    end
    return make_point(int'($urandom), int'($urandom));
  endfunction

  // transfer happens at the first edge with start high and busy low
  task automatic send_point(input in_item_t pt, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= pt;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [ITER_W-1:0] iters, input logic [LIMIT_W-1:0] esc,
                               input logic [LIMIT_W-1:0] b1, input logic [LIMIT_W-1:0] b2);
    logic [LIMIT_W-ITER_W-1:0] junk;
    junk = ($urandom_range(0, 1) == 0) ? '0 : (LIMIT_W - ITER_W)'($urandom);
    drain_results();
    repeat (3) @(posedge clk);
    cfg_write(REG_MAX_ITERS, {junk, iters});
    cfg_write(REG_ESCAPE_LIMIT, esc);
    cfg_write(REG_BAND_ONE_LIMIT, b1);
    cfg_write(REG_BAND_TWO_LIMIT, b2);
    // unmapped index, must leave every register alone
    cfg_write(CFG_IDX_W'(int'(REG_BAND_TWO_LIMIT) + 1 + int'($urandom_range(0, 3))),
              LIMIT_W'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    logic [ITER_W-1:0]  iters;
    logic [LIMIT_W-1:0] esc;
    logic [LIMIT_W-1:0] b1;
    logic [LIMIT_W-1:0] b2;
    int                 count;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults after reset
    send_point(make_point(0, 0), pick_gap());
    send_point(make_point(-2 * Q_ONE, 0), pick_gap());
    send_point(make_point(2 * Q_ONE, 0), pick_gap());
    send_point(make_point(34393293, 0), pick_gap());
    send_point(make_point(38587597, 0), pick_gap());
    send_point(make_point(3 * Q_ONE, 0), pick_gap());
    send_point(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF), pick_gap());
    send_point(make_point(32'h8000_0000, 32'h8000_0000), pick_gap());
    send_point(make_point(32'h8000_0000, 32'h7FFF_FFFF), pick_gap());
    send_point(make_point(32'h7FFF_FFFF, 32'h8000_0000), pick_gap());
    send_point(make_point(0, Q_ONE), pick_gap());
    send_point(make_point(-Q_ONE, 0), pick_gap());
    send_point(make_point(-12582912, 1677722), pick_gap());
    send_point(make_point(4362076, 0), pick_gap());
    send_point(make_point(Q_ONE, Q_ONE), pick_gap());
    send_point(make_point(-1, -1), pick_gap());

    // no iterations at all
    apply_setting('0, RST_ESCAPE_LIMIT, RST_BAND_ONE_LIMIT, RST_BAND_TWO_LIMIT);
    send_point(make_point(0, 0), pick_gap());
    send_point(make_point(3 * Q_ONE, -3 * Q_ONE), pick_gap());

    // zero bounds: any positive magnitude escapes
    apply_setting(8'd1, '0, '0, '0);
    send_point(make_point(0, 0), pick_gap());
    send_point(make_point(Q_ONE, 0), pick_gap());
    send_point(make_point(32'h7FFF_FFFF, 0), pick_gap());

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      count = 135;
      case (ph)
        0: begin
          iters = 8'd255;
          esc   = RST_ESCAPE_LIMIT;
          b1    = RST_BAND_ONE_LIMIT;
          b2    = RST_BAND_TWO_LIMIT;
          count = 30;
        end
        1: begin
          iters = ITER_W'($urandom_range(1, 16));
          esc   = '0;
          b1    = '0;
          b2    = '0;
        end
        2: begin
          iters = ITER_W'($urandom_range(1, 24));
          esc   = LIMIT_MAX;
          b1    = LIMIT_W'($urandom);
          b2    = LIMIT_W'($urandom);
        end
        3: begin
          iters = ITER_W'($urandom_range(1, 40));
          esc   = LIMIT_W'(4 * Q_ONE);
          b1    = LIMIT_W'(Q_ONE);
          b2    = LIMIT_W'(6 * Q_ONE);
        end
        4: begin
          iters = ITER_W'($urandom_range(1, 40));
          esc   = LIMIT_W'(2 * Q_ONE);
          b1    = LIMIT_W'(8 * Q_ONE);
          b2    = LIMIT_W'(3 * Q_ONE);
        end
        5: begin
          iters = 8'd1;
          esc   = LIMIT_W'(4 * Q_ONE);
          b1    = LIMIT_MAX;
          b2    = LIMIT_MAX;
        end
        default: begin
          iters = ITER_W'($urandom_range(1, 48));
          if ($urandom_range(0, 3) == 0) begin
            esc = LIMIT_W'($urandom);
            b1  = LIMIT_W'($urandom);
            b2  = LIMIT_W'($urandom);
          end else begin
            esc = LIMIT_W'($urandom_range(0, 16 * Q_ONE));
            b1  = LIMIT_W'(esc + $urandom_range(0, 4 * Q_ONE));
            b2  = LIMIT_W'(b1 + $urandom_range(0, 8 * Q_ONE));
          end
        end
      endcase
      apply_setting(iters, esc, b1, b2);
      for (int k = 0; k < count; k++) begin
        send_point(rand_point(), pick_gap());
        if ($urandom_range(0, 49) == 0) begin
          drain_results();
        end
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("mandelbrot_escape_classifier_top: match");
    end else begin
      $display("mandelbrot_escape_classifier_top: mismatch");
    end
    $finish;
  end

endmodule
